@@ src/saturating_pcm_mixer_assert.svh @@
// Assertion macros for the saturating PCM mixer.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef SATURATING_PCM_MIXER_ASSERT_SVH
`define SATURATING_PCM_MIXER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMIX_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMIX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/smix_pkg.sv @@
// Package of the saturating PCM mixer: field widths, types, register indexes,
// constants and the drain formatting functions. No dependencies.
`default_nettype none

package smix_pkg;

   localparam int TIME_W      = 32;
   localparam int SAMPLE_W    = 16;
   localparam int GAIN_W      = 8;
   localparam int VOL_W       = 9;
   localparam int SCALE_W     = GAIN_W + VOL_W;
   localparam int PROD_W      = 34;
   localparam int ACC_W       = 32;
   localparam int WORD_W      = 16;
   localparam int ADDR_W      = 16;
   localparam int RING_W      = 5;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 9;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [GAIN_W-1:0]          gain_type;
   typedef logic [VOL_W-1:0]           vol_type;
   typedef logic [SCALE_W-1:0]         scale_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic [ACC_W-1:0]           acc_type;
   typedef logic [WORD_W-1:0]          word_type;
   typedef logic [ADDR_W-1:0]          addr_type;
   typedef logic [RING_W-1:0]          ring_type;

   // Register indexes on the configuration channel.
   localparam logic [CSR_INDEX_W-1:0] CSR_MASTER_VOLUME  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_STEREO_OUT     = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_EIGHT_BIT_OUT  = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_RING_SIZE_LOG2 = CSR_INDEX_W'(3);

   localparam logic FUNC_MIX   = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   localparam vol_type  MASTER_VOLUME_RESET  = VOL_W'(256);
   localparam logic     STEREO_OUT_RESET     = 1'b1;
   localparam logic     EIGHT_BIT_OUT_RESET  = 1'b0;
   localparam ring_type RING_SIZE_LOG2_RESET = RING_W'(14);

   localparam word_type   SAT_MAX    = 16'h7fff;
   localparam word_type   SAT_MIN    = 16'h8000;
   localparam logic [7:0] OFFSET_BIN = 8'h80;

   // Arithmetic shift right by eight, then clamp to the signed 16-bit range.
   // The shifted value fits when bits 31 down to 23 all agree.
   function automatic word_type saturate(input acc_type acc);
      logic [7:0] top;
      top = acc[30:23];
      if (!acc[31] && (top != 8'h00)) begin
         return SAT_MAX;
      end else if (acc[31] && (top != 8'hff)) begin
         return SAT_MIN;
      end
      return acc[23:8];
   endfunction

   function automatic word_type format_word(input word_type v, input logic eight_bit);
      logic [7:0] byte_val;
      byte_val = v[15:8] + OFFSET_BIN;
      return eight_bit ? {8'h00, byte_val} : v;
   endfunction

   // Ring address mask; sizes of sixteen and above keep every address bit.
   function automatic addr_type ring_mask(input ring_type size_log2);
      addr_type m;
      for (int i = 0; i < ADDR_W; i++) begin
         m[i] = (RING_W'(i) < size_log2);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

@@ src/smix_channels.sv @@
// Valid/ready channel interfaces of the saturating PCM mixer: input items,
// result words and configuration writes. Depends on smix_pkg.
`default_nettype none

interface smix_req_if import smix_pkg::*;;
   logic             valid;
   logic             ready;
   logic             func;
   logic [TIME_W-1:0] sample_time;
   sample_type       sample_left;
   sample_type       sample_right;
   gain_type         gain_left;
   gain_type         gain_right;
   logic             use_master;

   modport source (output valid, func, sample_time, sample_left, sample_right,
                   gain_left, gain_right, use_master, input ready);
   modport sink (input valid, func, sample_time, sample_left, sample_right,
                 gain_left, gain_right, use_master, output ready);
endinterface

interface smix_rsp_if import smix_pkg::*;;
   logic     valid;
   logic     ready;
   word_type out_word;
   addr_type out_address;
   logic     last;

   modport source (output valid, out_word, out_address, last, input ready);
   modport sink (input valid, out_word, out_address, last, output ready);
endinterface

interface smix_csr_if import smix_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/saturating_pcm_mixer.sv @@
// Saturating PCM mixer: one store of stereo mix accumulators with a
// read-modify-write sequencer and a registered result stage.
// Depends on smix_pkg, smix_channels.sv and saturating_pcm_mixer_assert.svh.
//
// The mixer holds MIX_ENTRIES stereo accumulators (a power of two) in one
// synchronous memory, addressed by the low bits of the sample time. Items are
// handled one at a time: a mix goes through read and gain scaling, sample
// multiply, then accumulate and write back; a drain clears the entry and gives
// the left word and, in stereo, the right word as the output register frees.
// The order is set by the single read-modify-write path through the accumulator
// memory. A finished word waits in the output register while the next item is
// taken. After reset a clearing pass zeroes the store, during which no item is
// accepted; configuration writes are taken at all times.
`default_nettype none

`include "saturating_pcm_mixer_assert.svh"

module saturating_pcm_mixer import smix_pkg::*; #(
   parameter int MIX_ENTRIES = 4096
) (
   input  logic       clock,
   input  logic       reset,
   smix_req_if.sink   req_if,
   smix_rsp_if.source rsp_if,
   smix_csr_if.sink   csr_if
);

   localparam int IDX_W = $clog2(MIX_ENTRIES);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_ADD   = 3'd3;
   localparam logic [2:0] ST_RIGHT = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;

   vol_type  master_volume_ff;
   logic     stereo_out_ff;
   logic     eight_bit_out_ff;
   ring_type ring_size_log2_ff;

   logic       func_ff, func_in;
   addr_type   time_ff, time_in;
   sample_type sample_l_ff, sample_l_in, sample_r_ff, sample_r_in;
   scale_type  scale_l_ff, scale_l_in, scale_r_ff, scale_r_in;
   prod_type   prod_l_ff, prod_l_in, prod_r_ff, prod_r_in;

   logic     rsp_valid_ff, rsp_valid_in;
   word_type rsp_word_ff, rsp_word_in;
   addr_type rsp_addr_ff, rsp_addr_in;
   logic     rsp_last_ff, rsp_last_in;

   logic [2*ACC_W-1:0] mix_store_ff [MIX_ENTRIES];
   logic [2*ACC_W-1:0] rd_ff;
   logic               mem_we, mem_re;
   logic [IDX_W-1:0]   mem_waddr, mem_raddr;
   logic [2*ACC_W-1:0] mem_wdata;

   logic     req_take, out_free;
   addr_type mask;
   acc_type  sum_l, sum_r;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_take     = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign mask         = ring_mask(ring_size_log2_ff);

   assign sum_l = rd_ff[ACC_W-1:0] + {{6{prod_l_ff[PROD_W-1]}}, prod_l_ff[PROD_W-1:8]};
   assign sum_r = rd_ff[2*ACC_W-1:ACC_W] + {{6{prod_r_ff[PROD_W-1]}}, prod_r_ff[PROD_W-1:8]};

   assign mem_re    = req_take;
   assign mem_raddr = req_if.sample_time[IDX_W-1:0];

   // Sequencer and datapath next values.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      func_in      = func_ff;
      time_in      = time_ff;
      sample_l_in  = sample_l_ff;
      sample_r_in  = sample_r_ff;
      scale_l_in   = scale_l_ff;
      scale_r_in   = scale_r_ff;
      prod_l_in    = prod_l_ff;
      prod_r_in    = prod_r_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_word_in  = rsp_word_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_waddr    = time_ff[IDX_W-1:0];
      mem_wdata    = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(MIX_ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               func_in     = req_if.func;
               time_in     = req_if.sample_time[ADDR_W-1:0];
               sample_l_in = req_if.sample_left;
               sample_r_in = req_if.sample_right;
               if (req_if.use_master) begin
                  scale_l_in = SCALE_W'(req_if.gain_left) * SCALE_W'(master_volume_ff);
                  scale_r_in = SCALE_W'(req_if.gain_right) * SCALE_W'(master_volume_ff);
               end else begin
                  scale_l_in = SCALE_W'(req_if.gain_left);
                  scale_r_in = SCALE_W'(req_if.gain_right);
               end
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (func_ff == FUNC_MIX) begin
               prod_l_in = prod_type'(sample_l_ff) * prod_type'($signed({1'b0, scale_l_ff}));
               prod_r_in = prod_type'(sample_r_ff) * prod_type'($signed({1'b0, scale_r_ff}));
               state_in  = ST_ADD;
            end else begin
               // The entry is cleared while the read data is held in rd_ff.
               mem_we = 1'b1;
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = format_word(saturate(rd_ff[ACC_W-1:0]), eight_bit_out_ff);
                  rsp_last_in  = !stereo_out_ff;
                  if (stereo_out_ff) begin
                     rsp_addr_in = {time_ff[ADDR_W-2:0], 1'b0} & mask;
                     state_in    = ST_RIGHT;
                  end else begin
                     rsp_addr_in = time_ff & mask;
                     state_in    = ST_IDLE;
                  end
               end
            end
         end
         ST_ADD: begin
            mem_we    = 1'b1;
            mem_wdata = {sum_r, sum_l};
            state_in  = ST_IDLE;
         end
         ST_RIGHT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = format_word(saturate(rd_ff[2*ACC_W-1:ACC_W]), eight_bit_out_ff);
               rsp_addr_in  = {time_ff[ADDR_W-2:0], 1'b1} & mask;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      time_ff     <= time_in;
      sample_l_ff <= sample_l_in;
      sample_r_ff <= sample_r_in;
      scale_l_ff  <= scale_l_in;
      scale_r_ff  <= scale_r_in;
      prod_l_ff   <= prod_l_in;
      prod_r_ff   <= prod_r_in;
      rsp_word_ff <= rsp_word_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Accumulator memory: left side in the low half, right side in the high half.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mix_store_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= mix_store_ff[mem_raddr];
      end
   end

   // Configuration registers.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         master_volume_ff  <= MASTER_VOLUME_RESET;
         stereo_out_ff     <= STEREO_OUT_RESET;
         eight_bit_out_ff  <= EIGHT_BIT_OUT_RESET;
         ring_size_log2_ff <= RING_SIZE_LOG2_RESET;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_MASTER_VOLUME:  master_volume_ff  <= csr_if.data[VOL_W-1:0];
            CSR_STEREO_OUT:     stereo_out_ff     <= csr_if.data[0];
            CSR_EIGHT_BIT_OUT:  eight_bit_out_ff  <= csr_if.data[0];
            CSR_RING_SIZE_LOG2: ring_size_log2_ff <= csr_if.data[RING_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.out_word    = rsp_word_ff;
   assign rsp_if.out_address = rsp_addr_ff;
   assign rsp_if.last        = rsp_last_ff;

   // A write and a read of the store never share a cycle, so no forwarding is needed.
   `SMIX_ASSERT_NOW(a_no_rw_overlap, clock, reset, mem_we, !mem_re, "store read and write overlap")
   `SMIX_ASSERT_NEXT(a_accept_reads, clock, reset, req_if.valid && req_if.ready, state_ff == ST_READ, "accepted transaction did not start a read")
   `SMIX_ASSERT_NOW(a_drain_clears, clock, reset, (state_ff == ST_READ) && (func_ff == FUNC_DRAIN) && mem_we, mem_wdata == '0, "drain does not clear the entry")
   // The left word of a stereo drain is always still held or just replaced.
   `SMIX_ASSERT_NOW(a_right_after_left, clock, reset, state_ff == ST_RIGHT, rsp_valid_ff, "right word pending without a left word")

endmodule

`default_nettype wire

@@ tb/sv/smix_checker.sv @@
`timescale 1ns / 100ps
// Checker for the saturating PCM mixer: watches the item, result and register
// channels, predicts every drained word and compares it with the block's output.
// Depends on smix_pkg and the channel interfaces in smix_channels.sv.

module smix_checker import smix_pkg::*; #(
   parameter int MIX_ENTRIES = 4096
) (
   input  logic clock,
   input  logic reset,
   smix_req_if  req_if,
   smix_rsp_if  rsp_if,
   smix_csr_if  csr_if,
   output int   mismatch_count,
   output int   words_due
);

   typedef struct packed {
      word_type word;
      addr_type address;
      logic     last;
   } ring_word_type;

   acc_type       acc_left  [MIX_ENTRIES];
   acc_type       acc_right [MIX_ENTRIES];
   vol_type       master_volume;
   logic          stereo_out;
   logic          eight_bit_out;
   ring_type      ring_size_log2;
   ring_word_type expected_words[$];
   int            errors;

   // Full-width product, then a flooring shift; the accumulator keeps 32 bits.
   function automatic acc_type scaled_sample(input sample_type s, input gain_type g,
                                             input logic with_master);
      longint vol;
      longint prod;
      vol = longint'(g);
      if (with_master) begin
         vol = vol * longint'(master_volume);
      end
      prod = longint'(s) * vol;
      return acc_type'(prod >>> 8);
   endfunction

   function automatic sample_type clamp_side(input acc_type acc);
      longint v;
      v = longint'($signed(acc)) >>> 8;
      if (v > 32767) begin
         v = 32767;
      end else if (v < -32768) begin
         v = -32768;
      end
      return sample_type'(v);
   endfunction

   function automatic word_type ring_format(input sample_type v);
      longint b;
      if (eight_bit_out) begin
         b = (longint'(v) >>> 8) + 128;
         return {8'h00, b[7:0]};
      end
      return word_type'(v);
   endfunction

   task automatic apply_source_item();
      int unsigned   idx;
      int            chans;
      longint        mask;
      longint        base;
      ring_word_type w;
      idx = req_if.sample_time % MIX_ENTRIES;
      if (req_if.func == FUNC_MIX) begin
         acc_left[idx]  = acc_left[idx] + scaled_sample(req_if.sample_left, req_if.gain_left,
                                                        req_if.use_master);
         acc_right[idx] = acc_right[idx] + scaled_sample(req_if.sample_right,
                                                         req_if.gain_right, req_if.use_master);
      end else begin
         chans = stereo_out ? 2 : 1;
         mask  = ((longint'(1) << ring_size_log2) - 1) & 64'hffff;
         base  = longint'(req_if.sample_time) * chans;
         for (int k = 0; k < chans; k++) begin
            w.word    = ring_format(clamp_side(k == 0 ? acc_left[idx] : acc_right[idx]));
            w.address = addr_type'((base + k) & mask);
            w.last    = (k == chans - 1);
            expected_words.push_back(w);
         end
         acc_left[idx]  = '0;
         acc_right[idx] = '0;
      end
   endtask

   always @(posedge clock) begin : monitor
      ring_word_type due;
      if (reset) begin
         foreach (acc_left[i]) begin
            acc_left[i]  = '0;
            acc_right[i] = '0;
         end
         master_volume  = MASTER_VOLUME_RESET;
         stereo_out     = STEREO_OUT_RESET;
         eight_bit_out  = EIGHT_BIT_OUT_RESET;
         ring_size_log2 = RING_SIZE_LOG2_RESET;
         expected_words.delete();
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_MASTER_VOLUME:  master_volume  = vol_type'(csr_if.data);
               CSR_STEREO_OUT:     stereo_out     = csr_if.data[0];
               CSR_EIGHT_BIT_OUT:  eight_bit_out  = csr_if.data[0];
               CSR_RING_SIZE_LOG2: ring_size_log2 = ring_type'(csr_if.data);
               default: ;
            endcase
         end
         // Results are compared before this edge's item is predicted, so a word
         // can never be matched against an expectation raised in the same cycle.
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_words.size() == 0) begin
               errors++;
               $error("unexpected result: out_word %h, out_address %h, last %b",
                      rsp_if.out_word, rsp_if.out_address, rsp_if.last);
            end else begin
               due = expected_words.pop_front();
               if (rsp_if.out_word !== due.word) begin
                  errors++;
                  $error("out_word: expected %h, got %h", due.word, rsp_if.out_word);
               end
               if (rsp_if.out_address !== due.address) begin
                  errors++;
                  $error("out_address: expected %h, got %h", due.address, rsp_if.out_address);
               end
               if (rsp_if.last !== due.last) begin
                  errors++;
                  $error("last: expected %b, got %b", due.last, rsp_if.last);
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            apply_source_item();
         end
      end
      words_due      <= expected_words.size();
      mismatch_count <= errors;
   end

endmodule

@@ tb/sv/tb_saturating_pcm_mixer.sv @@
`timescale 1ns / 100ps
// Top of the saturating PCM mixer testbench: clock, reset, item and register
// stimulus, result back-pressure and the verdict. Depends on smix_pkg,
// smix_channels.sv, saturating_pcm_mixer and smix_checker.

module tb_saturating_pcm_mixer import smix_pkg::*;;

   localparam int MIX_ENTRIES = 4096;
   localparam int CYCLE_LIMIT = 400_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS = 85;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = CSR_INDEX_W'(15);
   localparam sample_type SAMPLE_MAX = 16'sh7fff;
   localparam sample_type SAMPLE_MIN = 16'sh8000;

   logic clock = 1'b0;
   logic reset;
   logic req_gaps_on = 1'b0;
   logic rsp_stalls_on = 1'b0;
   int   mismatch_count;
   int   words_due;
   int   cycle_count;

   smix_req_if req_ch ();
   smix_rsp_if rsp_ch ();
   smix_csr_if csr_ch ();

   saturating_pcm_mixer #(.MIX_ENTRIES(MIX_ENTRIES)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   smix_checker #(.MIX_ENTRIES(MIX_ENTRIES)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_ch),
      .rsp_if         (rsp_ch),
      .csr_if         (csr_ch),
      .mismatch_count (mismatch_count),
      .words_due      (words_due)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // Back-pressure if on: mostly short runs either way, now and then a long stall.
   initial begin : result_backpressure
      int run;
      int pick;
      rsp_ch.ready = 1'b0;
      run = 0;
      forever begin
         @(negedge clock);
         if (run > 0) begin
            run--;
         end else if (!rsp_stalls_on) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               rsp_ch.ready <= 1'b1;
               run = $urandom_range(0, 8);
            end else if (pick < 92) begin
               rsp_ch.ready <= 1'b0;
               run = $urandom_range(0, 2);
            end else begin
               rsp_ch.ready <= 1'b0;
               run = $urandom_range(10, 40);
            end
         end
      end
   end

   function automatic sample_type random_sample();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         return SAMPLE_MAX;
      end else if (pick < 20) begin
         return SAMPLE_MIN;
      end else if (pick < 25) begin
         return '0;
      end
      return sample_type'($urandom);
   endfunction

   function automatic gain_type random_gain();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         return 8'hff;
      end else if (pick < 15) begin
         return 8'h00;
      end
      return gain_type'($urandom);
   endfunction

   task automatic send_item(input logic func, input logic [TIME_W-1:0] t,
                            input sample_type sl, input sample_type sr,
                            input gain_type gl, input gain_type gr, input logic um);
      int gap;
      int pick;
      gap = 0;
      if (req_gaps_on) begin
         pick = $urandom_range(0, 99);
         if (pick >= 90) begin
            gap = $urandom_range(5, 30);
         end else if (pick >= 55) begin
            gap = $urandom_range(1, 3);
         end
      end
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.func         <= func;
      req_ch.sample_time  <= t;
      req_ch.sample_left  <= sl;
      req_ch.sample_right <= sr;
      req_ch.gain_left    <= gl;
      req_ch.gain_right   <= gr;
      req_ch.use_master   <= um;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Drain items carry random payload in the fields that a drain ignores.
   task automatic drain_at(input logic [TIME_W-1:0] t);
      send_item(FUNC_DRAIN, t, sample_type'($urandom), sample_type'($urandom),
                gain_type'($urandom), gain_type'($urandom), 1'($urandom));
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // The single-bit registers only look at bit 0, so the rest is filled at random.
   task automatic set_mode(input vol_type vol, input logic stereo, input logic eight_bit,
                           input ring_type ring);
      write_reg(CSR_MASTER_VOLUME, vol);
      write_reg(CSR_STEREO_OUT, {8'($urandom), stereo});
      write_reg(CSR_EIGHT_BIT_OUT, {8'($urandom), eight_bit});
      write_reg(CSR_RING_SIZE_LOG2, {4'($urandom), ring});
   endtask

   // Stop sending, wait for every drained word, then give a trailing mix time
   // to finish its write-back before anything else happens.
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (words_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input int items, input logic gaps, input logic stalls);
      int                sent;
      int                pick;
      int                burst;
      logic [TIME_W-1:0] t;
      logic [TIME_W-1:0] alias_t;
      req_gaps_on   = gaps;
      rsp_stalls_on = stalls;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            // A few sources mixed into one output sample, then drained.
            t = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 63);
            burst = $urandom_range(1, 6);
            repeat (burst) begin
               alias_t = t;
               if ($urandom_range(0, 4) == 0) begin
                  alias_t = t + MIX_ENTRIES * $urandom_range(1, 15);
               end
               send_item(FUNC_MIX, alias_t, random_sample(), random_sample(),
                         random_gain(), random_gain(), 1'($urandom));
            end
            drain_at(t);
            sent += burst + 1;
         end else if (pick < 87) begin
            drain_at($urandom);
            sent++;
         end else begin
            send_item(FUNC_MIX, $urandom, random_sample(), random_sample(),
                      random_gain(), random_gain(), 1'($urandom));
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.func         = FUNC_MIX;
      req_ch.sample_time  = '0;
      req_ch.sample_left  = '0;
      req_ch.sample_right = '0;
      req_ch.gain_left    = '0;
      req_ch.gain_right   = '0;
      req_ch.use_master   = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = CSR_MASTER_VOLUME;
      csr_ch.data         = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed items at the reset configuration.
      send_item(FUNC_MIX, 32'd5, SAMPLE_MAX, SAMPLE_MIN, 8'hff, 8'hff, 1'b1);
      drain_at(32'd5);
      // Two full-scale mixes push both sides past the 16-bit range.
      send_item(FUNC_MIX, 32'h0000_1000, SAMPLE_MAX, SAMPLE_MIN, 8'hff, 8'hff, 1'b1);
      send_item(FUNC_MIX, 32'h0000_1000, SAMPLE_MAX, SAMPLE_MIN, 8'hff, 8'hff, 1'b1);
      drain_at(32'hffff_f000);
      // A raw stream with the smallest negative term shows the flooring shift.
      send_item(FUNC_MIX, 32'd7, -16'sd1, 16'sd1, 8'h01, 8'h01, 1'b0);
      drain_at(32'd7);
      send_item(FUNC_MIX, 32'd9, SAMPLE_MIN, SAMPLE_MAX, 8'h00, 8'h00, 1'b1);
      drain_at(32'd9);
      drain_at(32'd12345);
      send_item(FUNC_MIX, 32'hffff_ffff, 16'sd12345, -16'sd12345, 8'h80, 8'h4d, 1'b1);
      send_item(FUNC_MIX, 32'hffff_ffff, SAMPLE_MAX, SAMPLE_MAX, 8'hff, 8'h01, 1'b0);
      drain_at(32'hffff_ffff);
      drain_at(32'hffff_ffff);

      run_phase(PHASE_ITEMS, 1'b0, 1'b0);

      // Mono, eight-bit, zero ring size and a master volume above unity. The
      // long burst wraps the accumulators round rather than saturating them.
      settle();
      set_mode(9'd511, 1'b0, 1'b1, 5'd0);
      repeat (140) begin
         send_item(FUNC_MIX, 32'd77, SAMPLE_MAX, SAMPLE_MIN, 8'hff, 8'hff, 1'b1);
      end
      drain_at(32'd77);
      run_phase(PHASE_ITEMS, 1'b1, 1'b1);

      settle();
      write_reg(CSR_UNMAPPED, 9'($urandom));
      set_mode(9'd0, 1'b1, 1'b1, 5'd31);
      run_phase(PHASE_ITEMS, 1'b1, 1'b1);

      settle();
      set_mode(9'd1, 1'b0, 1'b0, 5'd16);
      run_phase(PHASE_ITEMS, 1'b1, 1'b0);

      settle();
      set_mode(vol_type'($urandom_range(2, 510)), 1'b1, 1'b0, 5'd1);
      run_phase(PHASE_ITEMS, 1'b0, 1'b1);

      settle();
      set_mode(vol_type'($urandom), 1'($urandom), 1'($urandom), ring_type'($urandom));
      run_phase(PHASE_ITEMS, 1'b1, 1'b1);

      settle();
      set_mode(vol_type'($urandom), 1'($urandom), 1'($urandom),
               ring_type'($urandom_range(1, 16)));
      run_phase(PHASE_ITEMS, 1'b1, 1'b1);

      settle();
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+src
src/smix_pkg.sv
src/smix_channels.sv
src/saturating_pcm_mixer.sv
tb/sv/smix_checker.sv
tb/sv/tb_saturating_pcm_mixer.sv
